/* rtl/tfsd_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tfsd_pkg
// Shared types and codes for the tagged FIFO with selective dequeue: command
// and status codes, and the control bundle broadcast to every queue cell.
// ----------------------------------------------------------------------------
package tfsd_pkg;

    localparam int PAYLOAD_W = 32;
    localparam int PRIO_W    = 8;
    localparam int OCC_W     = 5;

    // Command codes carried on the input beat.
    typedef enum logic [1:0] {
        FUNC_ENQ       = 2'd0,
        FUNC_DEQ       = 2'd1,
        FUNC_DEQ_EXACT = 2'd2,
        FUNC_DEQ_AT_LEAST = 2'd3
    } func_t;

    // Status codes carried on the result beat.
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_NOMATCH = 2'd3
    } status_t;

    // Control broadcast to every cell in the cycle a command is taken.
    typedef struct packed {
        logic                enq;   // store the new entry at the tail
        logic                deq;   // a removal command is being executed
        func_t               func;
        logic [PRIO_W-1:0]   prio;
        logic [PAYLOAD_W-1:0] payload;
    } tfsd_ctl_t;

endpackage : tfsd_pkg
`default_nettype wire

/* rtl/tfsd_cell.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tfsd_cell
// One queue slot. It compares its priority against the command, passes the
// first-match flag and the removed payload to the next cell, and takes its
// right neighbor's entry when a removal closes the gap at or before it.
// ----------------------------------------------------------------------------
module tfsd_cell
    import tfsd_pkg::*;
(
    input  wire logic                 aclk,
    input  wire tfsd_ctl_t            ctl,
    input  wire logic                 occupied,
    input  wire logic                 load_here,
    input  wire logic [PAYLOAD_W-1:0] nb_payload,
    input  wire logic [PRIO_W-1:0]    nb_prio,
    input  wire logic                 found_in,
    input  wire logic [PAYLOAD_W-1:0] removed_in,
    output logic                      found_out,
    output logic [PAYLOAD_W-1:0]      removed_out,
    output logic [PAYLOAD_W-1:0]      cell_payload,
    output logic [PRIO_W-1:0]         cell_prio
);

    logic [PAYLOAD_W-1:0] payload_reg, payload_next;
    logic [PRIO_W-1:0]    prio_reg, prio_next;
    logic                 hit;
    logic                 first_hit;
    logic                 shift;

    // Match test for the command under way.
    always_comb begin
        case (ctl.func)
            FUNC_DEQ:       hit = occupied;
            FUNC_DEQ_EXACT: hit = occupied && (prio_reg == ctl.prio);
            FUNC_DEQ_AT_LEAST: hit = occupied && (prio_reg >= ctl.prio);
            default:        hit = 1'b0;
        endcase
    end

    // First-match ripple: only the oldest hit hands out its payload.
    assign first_hit   = hit && !found_in;
    assign found_out   = found_in || hit;
    assign removed_out = removed_in | (first_hit ? payload_reg : '0);

    // Every cell from the removed one onward takes its neighbor's entry.
    assign shift = ctl.deq && found_out;

    always_comb begin
        payload_next = payload_reg;
        prio_next    = prio_reg;
        if (ctl.enq && load_here) begin
            payload_next = ctl.payload;
            prio_next    = ctl.prio;
        end else if (shift) begin
            payload_next = nb_payload;
            prio_next    = nb_prio;
        end
    end

    always_ff @(posedge aclk) begin
        payload_reg <= payload_next;
        prio_reg    <= prio_next;
    end

    assign cell_payload = payload_reg;
    assign cell_prio    = prio_reg;

endmodule : tfsd_cell
`default_nettype wire

/* rtl/tagged_fifo_selective_dequeue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tagged_fifo_selective_dequeue
// Ordered queue of payload handles with priorities; removal of the oldest
// entry, of the oldest exact-priority entry, or of the oldest entry at or
// above a threshold, with the gap closed in the same cycle.
// ----------------------------------------------------------------------------
// Usage:
//   The s_ channel carries one command per beat: s_func selects enqueue or
//   one of three removals, s_payload_in and s_prio carry the entry or the
//   match value. The m_ channel returns one result beat per command with
//   m_status, m_payload_out (zero unless an entry was removed) and
//   m_occupancy, the entry count after the command.
//   The result beat is valid the cycle after the command beat is taken.
//   Throughput is one command per cycle while m_ready stays high; the cells
//   compare in parallel, and the first-match ripple through the row of
//   DEPTH cells plus the shift sets the cycle's logic depth.
//   Reset (aresetn low, synchronous) empties the queue and drops any pending
//   result; cell contents are not cleared since empty cells are never read.
//   When the receiver holds m_ready low, the result stays in the output
//   register and s_ready falls until that beat is taken, so no command is
//   executed without a place for its result.
// ----------------------------------------------------------------------------
module tagged_fifo_selective_dequeue
    import tfsd_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [1:0]           s_func,
    input  wire logic [PAYLOAD_W-1:0] s_payload_in,
    input  wire logic [PRIO_W-1:0]    s_prio,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [1:0]                m_status,
    output logic [PAYLOAD_W-1:0]      m_payload_out,
    output logic [OCC_W-1:0]          m_occupancy
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 m_valid_reg, m_valid_next;
    status_t              m_status_reg, m_status_next;
    logic [PAYLOAD_W-1:0] m_payload_reg, m_payload_next;

    logic                 s_fire;
    logic                 full;
    logic                 empty;
    func_t                func;
    tfsd_ctl_t            ctl;

    logic [PAYLOAD_W-1:0] nb_payload [DEPTH+1];
    logic [PRIO_W-1:0]    nb_prio    [DEPTH+1];
    logic                 found      [DEPTH+1];
    logic [PAYLOAD_W-1:0] removed    [DEPTH+1];

    assign s_ready = !m_valid_reg || m_ready;
    assign s_fire  = s_valid && s_ready;
    assign func    = func_t'(s_func);
    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);

    // Control broadcast to the row of cells.
    always_comb begin
        ctl.enq     = s_fire && (func == FUNC_ENQ) && !full;
        ctl.deq     = s_fire && (func != FUNC_ENQ);
        ctl.func    = func;
        ctl.prio    = s_prio;
        ctl.payload = s_payload_in;
    end

    // Chain ends: nothing found before the head, nothing beyond the tail.
    assign found[0]          = 1'b0;
    assign removed[0]        = '0;
    assign nb_payload[DEPTH] = '0;
    assign nb_prio[DEPTH]    = '0;

    // Row of cells, head at index zero.
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        tfsd_cell u_cell (
            .aclk         (aclk),
            .ctl          (ctl),
            .occupied     (CNT_W'(i) < count_reg),
            .load_here    (CNT_W'(i) == count_reg),
            .nb_payload   (nb_payload[i+1]),
            .nb_prio      (nb_prio[i+1]),
            .found_in     (found[i]),
            .removed_in   (removed[i]),
            .found_out    (found[i+1]),
            .removed_out  (removed[i+1]),
            .cell_payload (nb_payload[i]),
            .cell_prio    (nb_prio[i])
        );
    end

    // Count update and result beat.
    always_comb begin
        count_next     = count_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_status_next  = m_status_reg;
        m_payload_next = m_payload_reg;
        if (s_fire) begin
            m_valid_next   = 1'b1;
            m_payload_next = '0;
            if (func == FUNC_ENQ) begin
                if (full) begin
                    m_status_next = ST_FULL;
                end else begin
                    m_status_next = ST_OK;
                    count_next    = count_reg + 1'b1;
                end
            end else if (empty) begin
                m_status_next = ST_EMPTY;
            end else if (!found[DEPTH]) begin
                m_status_next = ST_NOMATCH;
            end else begin
                m_status_next  = ST_OK;
                m_payload_next = removed[DEPTH];
                count_next     = count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_status_reg  <= m_status_next;
        m_payload_reg <= m_payload_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_payload_out = m_payload_reg;
    assign m_occupancy   = OCC_W'(count_reg);

    // The entry count never passes the depth.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    // An accepted enqueue into a non-full queue adds exactly one entry.
    a_enq_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && (func == FUNC_ENQ) && !full) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("enqueue did not grow the count by one");

    // A failed command returns a zero payload.
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_status_reg != ST_OK)) |-> (m_payload_reg == '0))
        else $error("nonzero payload on failed command");

    // While a result beat stalls, no command changes the queue.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |=> $stable(count_reg))
        else $error("queue changed while result stalled");

    // A successful removal lowers the count by one.
    a_deq_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && (func != FUNC_ENQ) && found[DEPTH])
            |=> count_reg == $past(count_reg) - 1'b1)
        else $error("removal did not shrink the count by one");

endmodule : tagged_fifo_selective_dequeue
`default_nettype wire

/* tb/sv/tfsd_queue_monitor.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tfsd_queue_monitor
// Watches both channels of the tagged FIFO, keeps its own ordered copy of the
// held entries and checks every result beat against the predicted one.
// ----------------------------------------------------------------------------
module tfsd_queue_monitor
    import tfsd_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    input  wire logic                 s_ready,
    input  wire logic [1:0]           s_func,
    input  wire logic [PAYLOAD_W-1:0] s_payload_in,
    input  wire logic [PRIO_W-1:0]    s_prio,
    input  wire logic                 m_valid,
    input  wire logic                 m_ready,
    input  wire logic [1:0]           m_status,
    input  wire logic [PAYLOAD_W-1:0] m_payload_out,
    input  wire logic [OCC_W-1:0]     m_occupancy,
    output int                        fail_count,
    output int                        pending,
    output int                        n_ok,
    output int                        n_full,
    output int                        n_empty,
    output int                        n_nomatch
);

    typedef struct packed {
        logic [PAYLOAD_W-1:0] payload;
        logic [PRIO_W-1:0]    prio;
    } entry_t;

    typedef struct packed {
        status_t              status;
        logic [PAYLOAD_W-1:0] payload;
        logic [OCC_W-1:0]     occ;
    } outcome_t;

    // Entries in arrival order, head at index zero.
    entry_t   held_entries[$];
    // Results predicted for accepted commands, oldest first.
    outcome_t awaited_results[$];

    initial begin
        fail_count = 0;
        pending    = 0;
        n_ok       = 0;
        n_full     = 0;
        n_empty    = 0;
        n_nomatch  = 0;
    end

    // Applies one command to the held entries and returns its result.
    function automatic outcome_t queue_apply(func_t f, logic [PAYLOAD_W-1:0] pay,
                                             logic [PRIO_W-1:0] pr);
        outcome_t res;
        entry_t   ent;
        int       hit_at;
        res.status  = ST_OK;
        res.payload = '0;
        hit_at      = -1;
        if (f == FUNC_ENQ) begin
            if (held_entries.size() >= DEPTH) begin
                res.status = ST_FULL;
            end else begin
                ent.payload = pay;
                ent.prio    = pr;
                held_entries.push_back(ent);
            end
        end else if (held_entries.size() == 0) begin
            res.status = ST_EMPTY;
        end else begin
            // The first hit from the head is the oldest match.
            foreach (held_entries[i]) begin
                if (hit_at < 0) begin
                    case (f)
                        FUNC_DEQ:       hit_at = i;
                        FUNC_DEQ_EXACT: if (held_entries[i].prio == pr) hit_at = i;
                        default:        if (held_entries[i].prio >= pr) hit_at = i;
                    endcase
                end
            end
            if (hit_at < 0) begin
                res.status = ST_NOMATCH;
            end else begin
                res.payload = held_entries[hit_at].payload;
                held_entries.delete(hit_at);
            end
        end
        res.occ = OCC_W'(held_entries.size());
        return res;
    endfunction

    // Check result beats first: a result never belongs to a command taken
    // at the same edge, since the result beat is registered.
    always @(posedge aclk) begin : watch
        outcome_t want;
        if (!aresetn) begin
            held_entries.delete();
            awaited_results.delete();
            pending <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (awaited_results.size() == 0) begin
                    $error("Result beat with no command outstanding");
                    fail_count++;
                end else begin
                    want = awaited_results.pop_front();
                    if (m_status !== want.status) begin
                        $error("m_status: expected %0d, actual %0d", want.status, m_status);
                        fail_count++;
                    end
                    if (m_payload_out !== want.payload) begin
                        $error("m_payload_out: expected %h, actual %h",
                               want.payload, m_payload_out);
                        fail_count++;
                    end
                    if (m_occupancy !== want.occ) begin
                        $error("m_occupancy: expected %0d, actual %0d",
                               want.occ, m_occupancy);
                        fail_count++;
                    end
                    case (want.status)
                        ST_OK:    n_ok++;
                        ST_FULL:  n_full++;
                        ST_EMPTY: n_empty++;
                        default:  n_nomatch++;
                    endcase
                end
            end
            if (s_valid && s_ready) begin
                awaited_results.push_back(queue_apply(func_t'(s_func), s_payload_in, s_prio));
            end
            pending <= awaited_results.size();
        end
    end

endmodule : tfsd_queue_monitor

/* tb/sv/tb_tagged_fifo_selective_dequeue.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_tagged_fifo_selective_dequeue
// Drives directed and then phased random commands into the tagged FIFO,
// with random idling on both channels and long result stalls, and lets the
// queue monitor judge every result beat.
// ----------------------------------------------------------------------------
module tb_tagged_fifo_selective_dequeue;
    import tfsd_pkg::*;

    localparam int DEPTH        = 16;
    localparam int RANDOM_ITEMS = 1430;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int QUIET_FROM   = 1100;
    localparam int QUIET_TO     = 1500;
    localparam int HOLD_CYCLES  = 60;

    logic                 aclk          = 1'b0;
    logic                 aresetn       = 1'b0;
    logic                 s_valid       = 1'b0;
    logic [1:0]           s_func        = FUNC_ENQ;
    logic [PAYLOAD_W-1:0] s_payload_in  = '0;
    logic [PRIO_W-1:0]    s_prio        = '0;
    logic                 m_ready       = 1'b0;
    logic                 s_ready;
    logic                 m_valid;
    logic [1:0]           m_status;
    logic [PAYLOAD_W-1:0] m_payload_out;
    logic [OCC_W-1:0]     m_occupancy;

    int cycle_count = 0;
    int hold_left   = 0;
    int fail_count;
    int pending;
    int n_ok;
    int n_full;
    int n_empty;
    int n_nomatch;

    logic quiet;
    assign quiet = (cycle_count >= QUIET_FROM) && (cycle_count < QUIET_TO);

    tagged_fifo_selective_dequeue #(
        .DEPTH(DEPTH)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_func(s_func),
        .s_payload_in(s_payload_in),
        .s_prio(s_prio),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_status(m_status),
        .m_payload_out(m_payload_out),
        .m_occupancy(m_occupancy)
    );

    tfsd_queue_monitor #(
        .DEPTH(DEPTH)
    ) monitor (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_func(s_func),
        .s_payload_in(s_payload_in),
        .s_prio(s_prio),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_status(m_status),
        .m_payload_out(m_payload_out),
        .m_occupancy(m_occupancy),
        .fail_count(fail_count),
        .pending(pending),
        .n_ok(n_ok),
        .n_full(n_full),
        .n_empty(n_empty),
        .n_nomatch(n_nomatch)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // Cycle counter and run limit.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Receiver: random stalls, a quiet window, and two long hold-offs that
    // back the block up while the sender keeps offering commands.
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (cycle_count == 300 || cycle_count == 900) begin
            m_ready   <= 1'b0;
            hold_left <= HOLD_CYCLES;
        end else if (quiet) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(99) >= 6);
        end
    end

    // Offers one command beat and returns at the edge that takes it. Between beats
    // valid is only dropped here, before the next beat, so it never toggles in a step.
    task automatic send_cmd(func_t f, logic [PAYLOAD_W-1:0] pay, logic [PRIO_W-1:0] pr);
        if (!quiet && $urandom_range(99) < 6) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_func       <= f;
        s_payload_in <= pay;
        s_prio       <= pr;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    initial begin : stimulus
        int                issued;
        int                enq_pct;
        func_t             op;
        logic [PRIO_W-1:0] pr;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Removals of every kind on an empty queue.
        send_cmd(FUNC_DEQ,          32'h1234_5678, 8'h00);
        send_cmd(FUNC_DEQ_EXACT,    32'hFFFF_FFFF, 8'hFF);
        send_cmd(FUNC_DEQ_AT_LEAST, 32'h0000_0000, 8'h00);
        // Field extremes, and two entries sharing a priority.
        send_cmd(FUNC_ENQ,          32'h0000_0000, 8'h00);
        send_cmd(FUNC_ENQ,          32'hFFFF_FFFF, 8'hFF);
        send_cmd(FUNC_ENQ,          32'hA5A5_A5A5, 8'h07);
        send_cmd(FUNC_ENQ,          32'h5A5A_5A5A, 8'h07);
        // Several matches remove the oldest; then a miss on an exact value.
        send_cmd(FUNC_DEQ_EXACT,    32'h0,         8'h07);
        send_cmd(FUNC_DEQ_EXACT,    32'h0,         8'h64);
        // Threshold at the top, above every entry, and at zero.
        send_cmd(FUNC_DEQ_AT_LEAST, 32'h0,         8'hFF);
        send_cmd(FUNC_DEQ_AT_LEAST, 32'h0,         8'h08);
        send_cmd(FUNC_DEQ_AT_LEAST, 32'h0,         8'h00);
        send_cmd(FUNC_DEQ,          32'h0,         8'h00);
        send_cmd(FUNC_DEQ,          32'h0,         8'h00);
        // An entry removed from the middle of the threshold range.
        send_cmd(FUNC_ENQ,          32'h8000_0001, 8'h80);
        send_cmd(FUNC_DEQ_EXACT,    32'h0,         8'h00);
        send_cmd(FUNC_DEQ_AT_LEAST, 32'h0,         8'h01);
        send_cmd(FUNC_DEQ_EXACT,    32'h0,         8'hFF);

        // Random phases leaning to filling, draining or a balanced mix, so the
        // queue runs into both full and empty many times.
        issued = 0;
        while (issued < RANDOM_ITEMS) begin
            case ($urandom_range(2))
                0:       enq_pct = 85;
                1:       enq_pct = 15;
                default: enq_pct = 50;
            endcase
            repeat ($urandom_range(20, 60)) begin
                if ($urandom_range(99) < enq_pct) begin
                    op = FUNC_ENQ;
                end else begin
                    case ($urandom_range(2))
                        0:       op = FUNC_DEQ;
                        1:       op = FUNC_DEQ_EXACT;
                        default: op = FUNC_DEQ_AT_LEAST;
                    endcase
                end
                // Small priorities from 0 to 3 four draws in ten, so exact matches are common.
                case ($urandom_range(9))
                    0, 1, 2, 3: pr = PRIO_W'($urandom_range(3));
                    4:          pr = PRIO_W'(8'hFF - $urandom_range(1));
                    default:    pr = PRIO_W'($urandom);
                endcase
                send_cmd(op, $urandom, pr);
                issued++;
            end
        end
        s_valid <= 1'b0;

        // Drain every outstanding result, then allow a few quiet cycles.
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);

        $display("Ran %0d random commands after the directed set in %0d cycles.",
                 issued, cycle_count);
        $display("Results: %0d ok, %0d full, %0d empty, %0d no match.",
                 n_ok, n_full, n_empty, n_nomatch);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule : tb_tagged_fifo_selective_dequeue
